// ===== rtl/afa_pkg.sv =====
`default_nettype none
package afa_pkg;

   typedef enum logic [1:0] {
      CMD_FIRST = 2'd0,
      CMD_BEST  = 2'd1,
      CMD_WORST = 2'd2,
      CMD_FREE  = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_AWALK,
      ST_ASET,
      ST_ASPLIT,
      ST_FWALK,
      ST_MSTART,
      ST_MFIRST,
      ST_MWALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] request_size;
      logic [63:0] free_address;
   } req_type;

   typedef struct packed {
      logic [63:0] payload_address;
      logic        granted;
   } rsp_type;

   localparam int REQ_W = 16;
   localparam int CMP_W = 17;
   localparam int SUM_W = 18;

endpackage
`default_nettype wire

// ===== rtl/afa_hdr_ram.sv =====
`default_nettype none
module afa_hdr_ram
   import afa_pkg::*;
#(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 13
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/arena_fit_allocator.sv =====
`default_nettype none
// Heap allocator over one arena of address-ordered blocks (header + payload).
// req channel (valid/stall): cmd 0/1/2 allocates request_size bytes by first,
// best or worst fit; cmd 3 frees the block whose payload starts at
// free_address (zero is ignored). rsp channel (valid/stall) returns one beat
// per request: payload_address and granted.
// csr_wr_en/csr_wr_data write arena_base; write only while the block is idle.
// One request is handled at a time. Headers live in a single-port-write,
// registered-read RAM and the chain is walked one block per cycle:
//   allocate: visit each block, plus a check of the arena end when the walk
//   reaches it, then mark, split if room is left, and post the result;
//   free: visit each block up to and including the target, then a merge
//   pass over the blocks; a free of a bad address posts without a walk.
// After each posted result the block returns to idle, where the next request is taken.
// The next request is taken while the previous beat still waits on rsp_stall;
// the block holds its finished result until the output register frees up.
// Reset (synchronous) enters an init state that writes the single free block at
// offset 0, then accepts requests; arena_base resets to zero.
module arena_fit_allocator
   import afa_pkg::*;
#(
   parameter int ARENA_BYTES  = 4096,
   parameter int HEADER_BYTES = 24
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload,
   input  wire logic    csr_wr_en,
   input  wire logic [63:0] csr_wr_data
);

   localparam int IDX_W  = $clog2(ARENA_BYTES);
   localparam int OFF_W  = IDX_W + 1;
   localparam int SIZE_W = IDX_W;
   localparam int DATA_W = SIZE_W + 1;
   localparam logic [OFF_W-1:0] ARENA_OFF = OFF_W'(ARENA_BYTES);
   localparam logic [OFF_W-1:0] HDR       = OFF_W'(HEADER_BYTES);
   localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(ARENA_BYTES - HEADER_BYTES);

   state_type          state_ff, state_in;
   logic [OFF_W-1:0]   cur_ff, cur_in;
   logic [OFF_W-1:0]   nx_ff, nx_in;
   logic [OFF_W-1:0]   rel_ff, rel_in;
   cmd_type            cmd_ff, cmd_in;
   logic [REQ_W-1:0]   req_size_ff, req_size_in;
   logic               have_ff, have_in;
   logic [IDX_W-1:0]   pick_ff, pick_in;
   logic [SIZE_W-1:0]  pick_size_ff, pick_size_in;
   logic [SIZE_W-1:0]  csize_ff, csize_in;
   logic               cused_ff, cused_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [63:0]        base_ff;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [DATA_W-1:0]  wr_data;
   logic [IDX_W-1:0]   rd_addr;
   logic [DATA_W-1:0]  rd_data;

   logic               req_fire;
   logic               rd_used;
   logic [SIZE_W-1:0]  rd_size;
   logic [OFF_W-1:0]   next_off;
   logic               at_end;
   logic               fit;
   logic               better;
   logic               split;
   logic [SUM_W-1:0]   nb_sum;
   logic [CMP_W-1:0]   rest_size;
   logic [63:0]        rel64;
   logic               rel_ok;
   logic               both_free;
   logic [OFF_W-1:0]   merged_off;
   logic [OFF_W-1:0]   n2;
   logic               rsp_load;

   afa_hdr_ram #(
      .ADDR_W(IDX_W),
      .DATA_W(DATA_W)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_fire = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rd_used = rd_data[DATA_W-1];
   assign rd_size = rd_data[SIZE_W-1:0];
   assign next_off = cur_ff + HDR + OFF_W'(rd_size);
   assign at_end = (cur_ff >= ARENA_OFF);
   assign fit = !rd_used && (CMP_W'(rd_size) >= CMP_W'(req_size_ff));
   assign better = !have_ff
                || ((cmd_ff == CMD_BEST) && (rd_size < pick_size_ff))
                || ((cmd_ff == CMD_WORST) && (rd_size > pick_size_ff));
   assign split = CMP_W'(pick_size_ff) > (CMP_W'(req_size_ff) + CMP_W'(HEADER_BYTES));
   assign nb_sum = SUM_W'(pick_ff) + SUM_W'(req_size_ff) + SUM_W'(HEADER_BYTES);
   assign rest_size = CMP_W'(pick_size_ff) - CMP_W'(req_size_ff) - CMP_W'(HEADER_BYTES);
   assign rel64 = req_payload.free_address - base_ff - 64'(HEADER_BYTES);
   assign rel_ok = (req_payload.free_address != 64'd0) && (rel64 < 64'(ARENA_BYTES));
   assign both_free = !cused_ff && !rd_used;
   assign merged_off = OFF_W'(csize_ff) + HDR + OFF_W'(rd_size);
   assign n2 = both_free ? (cur_ff + HDR + merged_off) : (nx_ff + HDR + OFF_W'(rd_size));
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_fire) begin
               if (req_payload.cmd != CMD_FREE) begin
                  state_in = ST_AWALK;
               end else if (rel_ok) begin
                  state_in = ST_FWALK;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_AWALK: begin
            if (at_end) begin
               state_in = have_ff ? ST_ASET : ST_DONE;
            end else if (fit && (cmd_ff == CMD_FIRST)) begin
               state_in = ST_ASET;
            end
         end
         ST_ASET: state_in = split ? ST_ASPLIT : ST_DONE;
         ST_ASPLIT: state_in = ST_DONE;
         ST_FWALK: begin
            if (at_end || (cur_ff > rel_ff)) begin
               state_in = ST_DONE;
            end else if (cur_ff == rel_ff) begin
               state_in = ST_MSTART;
            end
         end
         ST_MSTART: state_in = ST_MFIRST;
         ST_MFIRST: state_in = (next_off >= ARENA_OFF) ? ST_DONE : ST_MWALK;
         ST_MWALK: begin
            if (n2 >= ARENA_OFF) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      cur_in       = cur_ff;
      nx_in        = nx_ff;
      rel_in       = rel_ff;
      cmd_in       = cmd_ff;
      req_size_in  = req_size_ff;
      have_in      = have_ff;
      pick_in      = pick_ff;
      pick_size_in = pick_size_ff;
      csize_in     = csize_ff;
      cused_in     = cused_ff;
      res_in       = res_ff;
      wr_en        = 1'b0;
      wr_addr      = pick_ff;
      wr_data      = {1'b1, pick_size_ff};
      rd_addr      = cur_ff[IDX_W-1:0];
      case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = {1'b0, INIT_SIZE};
         end
         ST_IDLE: begin
            rd_addr     = '0;
            cur_in      = '0;
            have_in     = 1'b0;
            cmd_in      = req_payload.cmd;
            req_size_in = req_payload.request_size;
            rel_in      = rel64[OFF_W-1:0];
            res_in      = '0;
         end
         ST_AWALK: begin
            if (!at_end) begin
               if (fit && better) begin
                  have_in      = 1'b1;
                  pick_in      = cur_ff[IDX_W-1:0];
                  pick_size_in = rd_size;
               end
               cur_in  = next_off;
               rd_addr = next_off[IDX_W-1:0];
            end
         end
         ST_ASET: begin
            wr_en   = 1'b1;
            wr_addr = pick_ff;
            wr_data = {1'b1, split ? req_size_ff[SIZE_W-1:0] : pick_size_ff};
            res_in.payload_address = base_ff + 64'(pick_ff) + 64'(HEADER_BYTES);
            res_in.granted = 1'b1;
         end
         ST_ASPLIT: begin
            // leftover free block right after the granted payload
            wr_en   = 1'b1;
            wr_addr = nb_sum[IDX_W-1:0];
            wr_data = {1'b0, rest_size[SIZE_W-1:0]};
         end
         ST_FWALK: begin
            if (!at_end && (cur_ff == rel_ff)) begin
               wr_en   = 1'b1;
               wr_addr = cur_ff[IDX_W-1:0];
               wr_data = {1'b0, rd_size};
               res_in.granted = 1'b1;
            end else if (!at_end && (cur_ff < rel_ff)) begin
               cur_in  = next_off;
               rd_addr = next_off[IDX_W-1:0];
            end
         end
         ST_MSTART: begin
            rd_addr = '0;
            cur_in  = '0;
         end
         ST_MFIRST: begin
            csize_in = rd_size;
            cused_in = rd_used;
            nx_in    = next_off;
            rd_addr  = next_off[IDX_W-1:0];
         end
         ST_MWALK: begin
            // rd_data holds the block at nx; absorb it or advance
            if (both_free) begin
               wr_en    = 1'b1;
               wr_addr  = cur_ff[IDX_W-1:0];
               wr_data  = {1'b0, merged_off[SIZE_W-1:0]};
               csize_in = merged_off[SIZE_W-1:0];
            end else begin
               cur_in   = nx_ff;
               csize_in = rd_size;
               cused_in = rd_used;
            end
            nx_in   = n2;
            rd_addr = n2[IDX_W-1:0];
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_data_in  = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            base_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      nx_ff        <= nx_in;
      rel_ff       <= rel_in;
      cmd_ff       <= cmd_in;
      req_size_ff  <= req_size_in;
      have_ff      <= have_in;
      pick_ff      <= pick_in;
      pick_size_ff <= pick_size_in;
      csize_ff     <= csize_in;
      cused_ff     <= cused_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      !((state_ff == ST_IDLE) && wr_en))
      else $error("header write while idle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("request accepted but controller stayed idle");

   a_walk_advances: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_AWALK) && !at_end) |=> (cur_ff > $past(cur_ff)))
      else $error("allocation walk did not advance");

endmodule
`default_nettype wire

// ===== tb/tb_arena_fit_allocator.sv =====
`default_nettype none
module tb_arena_fit_allocator;
   import afa_pkg::*;

   localparam int ARENA  = 4096;
   localparam int HDR    = 24;
   localparam int WD_MAX = 20000;
   localparam int DRAIN  = 800;
   localparam int N_RAND = 1680;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_payload = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_payload;
   logic          csr_wr_en = 1'b0;
   logic [63:0]   csr_wr_data = '0;

   arena_fit_allocator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow of the header chain
   bit          blk_start [ARENA];
   bit          blk_used  [ARENA];
   int unsigned blk_size  [ARENA];
   bit          blk_seen  [ARENA];
   logic [63:0] base_q;
   int unsigned live_q [$];
   rsp_type     pending_q [$];

   int  errors = 0;
   int  n_alloc = 0, n_grant = 0, n_free = 0, n_rsp = 0;
   int  send_idle = 0, recv_idle = 0;
   bit  holdoff = 1'b0;
   int  quiet = 0;

   typedef struct {
      cmd_type     cmd;
      logic [15:0] size;
      logic [63:0] addr;
      bit          typed;
      logic [63:0] exp_addr;
      logic        exp_granted;
   } row_t;
   row_t dir_tab [$];

   function automatic int unsigned next_blk(int unsigned off);
      return off + HDR + blk_size[off];
   endfunction

   function automatic bit is_start(int unsigned off);
      return off < ARENA && blk_start[off];
   endfunction

   function automatic void coalesce();
      int unsigned cur, nx;
      cur = 0;
      while (is_start(cur)) begin
         nx = next_blk(cur);
         if (!is_start(nx)) break;
         if (!blk_used[cur] && !blk_used[nx]) begin
            blk_size[cur] += HDR + blk_size[nx];
            blk_start[nx] = 0;
            blk_used[nx]  = 0;
            blk_size[nx]  = 0;
         end else begin
            cur = nx;
         end
      end
   endfunction

   function automatic rsp_type heap_result(req_type r);
      rsp_type     o;
      int unsigned cur, pick, req, nb;
      bit          have;
      logic [63:0] rel;
      o = '0;
      req = r.request_size;
      if (r.cmd != CMD_FREE) begin
         cur = 0; have = 0; pick = 0;
         n_alloc++;
         while (is_start(cur)) begin
            if (!blk_used[cur] && blk_size[cur] >= req) begin
               if (!have) begin
                  have = 1; pick = cur;
                  if (r.cmd == CMD_FIRST) break;
               end else if (r.cmd == CMD_BEST && blk_size[cur] < blk_size[pick]) begin
                  pick = cur;
               end else if (r.cmd == CMD_WORST && blk_size[cur] > blk_size[pick]) begin
                  pick = cur;
               end
            end
            cur = next_blk(cur);
         end
         if (have) begin
            blk_used[pick] = 1;
            if (blk_size[pick] > req + HDR) begin
               nb = pick + HDR + req;
               if (nb < ARENA) begin
                  blk_start[nb] = 1; blk_used[nb] = 0; blk_seen[nb] = 1;
                  blk_size[nb]  = blk_size[pick] - req - HDR;
                  blk_size[pick] = req;
               end
            end
            o.payload_address = base_q + 64'(pick) + 64'(HDR);
            o.granted = 1'b1;
            live_q.push_back(pick);
            n_grant++;
         end
      end else if (r.free_address != 0) begin
         rel = r.free_address - base_q - 64'(HDR);
         if (rel < ARENA && blk_start[rel]) begin
            blk_used[rel] = 0;
            coalesce();
            o.granted = 1'b1;
            n_free++;
            foreach (live_q[i])
               if (live_q[i] == rel) begin
                  live_q.delete(i);
                  break;
               end
         end
      end
      return o;
   endfunction

   function automatic req_type rand_item();
      req_type     r;
      int          k, idx, tries;
      logic [63:0] rel;
      r = '0;
      r.request_size = 16'($urandom);
      r.free_address = {$urandom, $urandom};
      k = $urandom_range(0, 99);
      if (k < 50) begin
         r.cmd = cmd_type'($urandom_range(0, 2));
         k = $urandom_range(0, 99);
         if (k < 85)      r.request_size = 16'($urandom_range(0, 160));
         else if (k < 92) r.request_size = 16'($urandom_range(1000, 4072));
         else if (k < 97) r.request_size = 16'($urandom);
         else             r.request_size = 16'hFFFF;
      end else begin
         r.cmd = CMD_FREE;
         if (k < 85 && live_q.size() > 0) begin
            idx = $urandom_range(0, live_q.size() - 1);
            r.free_address = base_q + 64'(live_q[idx]) + 64'(HDR);
         end else if (k < 92) begin
            // only offsets whose header was written at some point
            idx = 0;
            for (tries = 0; tries < 64; tries++) begin
               idx = $urandom_range(0, ARENA - 1);
               if (blk_seen[idx]) break;
            end
            if (!blk_seen[idx]) idx = 0;
            r.free_address = base_q + 64'(idx) + 64'(HDR);
         end else if (k < 97) begin
            rel = r.free_address - base_q - 64'(HDR);
            if (rel < ARENA && !blk_seen[rel]) r.free_address = 0;
         end else begin
            r.free_address = 0;
         end
      end
      return r;
   endfunction

   task automatic send(req_type r, bit typed, rsp_type exp_r);
      rsp_type p;
      while (send_idle > 0 && $urandom_range(0, 99) < send_idle) @(negedge clock);
      req_payload = r;
      req_valid   = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = heap_result(r);
      pending_q.push_back(typed ? exp_r : p);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic settle_and_write(logic [63:0] val);
      while (pending_q.size() > 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = val;
      base_q      = val;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   // receiver stall; a hold-off request keeps it high for a long stretch
   always @(negedge clock) begin
      int n;
      if (holdoff) begin
         rsp_stall <= 1'b1;
         for (n = 0; n < 400; n++) @(negedge clock);
         holdoff <= 1'b0;
      end else begin
         rsp_stall <= (recv_idle > 0) && ($urandom_range(0, 99) < recv_idle);
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (rsp_valid && !rsp_stall) begin
         n_rsp++;
         if (pending_q.size() == 0) begin
            $error("unexpected beat addr=%h granted=%b",
                   rsp_payload.payload_address, rsp_payload.granted);
            errors++;
         end else begin
            e = pending_q.pop_front();
            if (rsp_payload.payload_address !== e.payload_address) begin
               $error("payload_address expected %h actual %h",
                      e.payload_address, rsp_payload.payload_address);
               errors++;
            end
            if (rsp_payload.granted !== e.granted) begin
               $error("granted expected %b actual %b", e.granted, rsp_payload.granted);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
      if (quiet >= WD_MAX) begin
         $display("tb_arena_fit_allocator failed");
         $finish;
      end
   end

   function automatic row_t mk(cmd_type c, int s, logic [63:0] a, bit t,
                               logic [63:0] ea, logic eg);
      row_t w;
      w.cmd = c; w.size = 16'(s); w.addr = a; w.typed = t;
      w.exp_addr = ea; w.exp_granted = eg;
      return w;
   endfunction

   initial begin
      req_type r;
      rsp_type e;
      int      ph, i;
      foreach (blk_start[j]) begin
         blk_start[j] = 0; blk_used[j] = 0; blk_size[j] = 0; blk_seen[j] = 0;
      end
      blk_start[0] = 1; blk_seen[0] = 1; blk_size[0] = ARENA - HDR;
      base_q = '0;

      dir_tab.push_back(mk(CMD_FIRST, 0,     64'd0,    1, 64'd24, 1'b1));
      dir_tab.push_back(mk(CMD_FIRST, 65535, 64'd0,    1, 64'd0,  1'b0));
      dir_tab.push_back(mk(CMD_FREE,  0,     64'd0,    1, 64'd0,  1'b0));
      dir_tab.push_back(mk(CMD_FREE,  0,     64'd24,   1, 64'd0,  1'b1));
      dir_tab.push_back(mk(CMD_FREE,  0,     '1,       1, 64'd0,  1'b0));
      dir_tab.push_back(mk(CMD_FIRST, 4072,  64'd0,    1, 64'd24, 1'b1));
      dir_tab.push_back(mk(CMD_FIRST, 0,     64'd0,    1, 64'd0,  1'b0));
      dir_tab.push_back(mk(CMD_FREE,  0,     64'd24,   1, 64'd0,  1'b1));
      dir_tab.push_back(mk(CMD_FREE,  0,     64'd24,   1, 64'd0,  1'b1));
      dir_tab.push_back(mk(CMD_FIRST, 100,   64'd0,    0, 0, 0));
      dir_tab.push_back(mk(CMD_FIRST, 300,   64'd0,    0, 0, 0));
      dir_tab.push_back(mk(CMD_FIRST, 100,   64'd0,    0, 0, 0));
      dir_tab.push_back(mk(CMD_FIRST, 50,    64'd0,    0, 0, 0));
      dir_tab.push_back(mk(CMD_FREE,  0,     64'd24,   0, 0, 0));
      dir_tab.push_back(mk(CMD_FREE,  0,     64'd472,  0, 0, 0));
      dir_tab.push_back(mk(CMD_BEST,  90,    64'd0,    0, 0, 0));
      dir_tab.push_back(mk(CMD_WORST, 10,    64'd0,    0, 0, 0));
      dir_tab.push_back(mk(CMD_FREE,  0,     64'd148,  0, 0, 0));
      dir_tab.push_back(mk(CMD_FIRST, 4073,  64'd0,    1, 64'd0,  1'b0));
      dir_tab.push_back(mk(CMD_FREE,  0,     64'd4120, 1, 64'd0,  1'b0));
      dir_tab.push_back(mk(CMD_FIRST, 32768, 64'd0,    1, 64'd0,  1'b0));

      repeat (3) @(negedge clock);
      reset = 1'b0;
      settle_and_write(64'd0);

      foreach (dir_tab[j]) begin
         r = '0;
         r.cmd = dir_tab[j].cmd;
         r.request_size = dir_tab[j].size;
         r.free_address = dir_tab[j].addr;
         e.payload_address = dir_tab[j].exp_addr;
         e.granted = dir_tab[j].exp_granted;
         send(r, dir_tab[j].typed, e);
      end

      for (ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle = 24; recv_idle = 82;
               // payload address of offset zero wraps to zero here
               settle_and_write(64'hFFFF_FFFF_FFFF_FFE8);
            end
            1: begin
               send_idle = 82; recv_idle = 24;
               settle_and_write({$urandom, $urandom});
            end
            default: begin
               send_idle = 0; recv_idle = 0;
               settle_and_write('1);
               holdoff = 1'b1;
            end
         endcase
         for (i = 0; i < N_RAND / 3; i++) send(rand_item(), 1'b0, '0);
      end

      i = 0;
      while (pending_q.size() > 0 && i < 200000) begin
         @(negedge clock);
         i++;
      end
      repeat (DRAIN) @(negedge clock);
      if (pending_q.size() > 0) begin
         $error("%0d beats never arrived", pending_q.size());
         errors++;
      end
      $display("covered %0d allocates (%0d granted), %0d frees done, %0d beats checked",
               n_alloc, n_grant, n_free, n_rsp);
      $display("across four arena base values including wrap and all ones");
      if (errors == 0) begin
         $display("tb_arena_fit_allocator passed");
      end else begin
         $display("tb_arena_fit_allocator failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
